// ===== rtl/core/crcft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crcft_pkg;

  // reflected crc-32 constants
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;

  // item kinds
  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_EOF  = 1'b1
  } kind_t;

  // one input item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
  } item_t;

  // one result item
  typedef struct packed {
    logic [31:0] file_crc;
    logic [31:0] file_length;
    logic [31:0] total_crc;
    logic [31:0] total_length;
    logic [31:0] file_count;
  } result_t;

  // one byte of the crc, lsb first, as an xor network of eight shift steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crc32_file_checksum_with_totals_top.sv =====
// crc-32 file checksum with running totals
//
// input channel (in_valid / in_ready, kind, data_byte): one transfer per
// file byte (kind 0), then one transfer with kind 1 to close the file.
// output channel (out_valid / out_ready): one transfer per closed file with
// the file crc, its length, the xor of all file crcs, the summed length and
// the file count. data bytes give no output transfer.
// throughput: one item per cycle while no file close waits; the byte crc
// step is a combinational xor network between the input register and the
// state registers. a file close passes through the input register, then
// the result register, to the output.
// when the receiver stalls, the result register holds; data bytes keep
// flowing, and a further file close waits in the input register, which
// then drops in_ready.
// reset: synchronous, active high; crc back to all ones, all counters and
// totals to zero, both registers empty.
`timescale 1ns / 1ps
`default_nettype none

module crc32_file_checksum_with_totals_top
  import crcft_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      file_crc,
  output logic [31:0]      file_length,
  output logic [31:0]      total_crc,
  output logic [31:0]      total_length,
  output logic [31:0]      file_count
);

  item_t   in_item;
  item_t   stg_item;
  logic    stg_valid;
  logic    stg_take;
  logic    res_space;
  logic    res_push;
  result_t res;
  result_t out_res;

  // pack input fields
  assign in_item.kind      = kind_t'(kind);
  assign in_item.data_byte = data_byte;

  // input register
  crcft_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .stg_valid (stg_valid),
    .stg_item  (stg_item),
    .stg_take  (stg_take)
  );

  // crc update and totals
  crcft_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .stg_valid (stg_valid),
    .stg_item  (stg_item),
    .stg_take  (stg_take),
    .res_space (res_space),
    .res_push  (res_push),
    .res       (res)
  );

  // result register
  crcft_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .res_push  (res_push),
    .res       (res),
    .res_space (res_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // unpack result fields
  assign file_crc     = out_res.file_crc;
  assign file_length  = out_res.file_length;
  assign total_crc    = out_res.total_crc;
  assign total_length = out_res.total_length;
  assign file_count   = out_res.file_count;

endmodule

`default_nettype wire

// ===== rtl/core/crcft_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crcft_in_stage
  import crcft_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       stg_valid,
  output item_t      stg_item,
  input  wire logic  stg_take
);

  // room when empty or when the held item leaves this cycle
  assign in_ready = !stg_valid || stg_take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  // payload captured on each input transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/crcft_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crcft_accum
  import crcft_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  stg_valid,
  input  wire item_t stg_item,
  output logic       stg_take,
  input  wire logic  res_space,
  output logic       res_push,
  output result_t    res
);

  logic [31:0] running_crc;
  logic [31:0] byte_count;
  logic [31:0] crc_accumulator;
  logic [31:0] length_sum;
  logic [31:0] files_done;

  logic        is_eof;
  logic        data_take;
  logic [31:0] final_crc;
  logic [31:0] crc_accumulator_next;
  logic [31:0] length_sum_next;
  logic [31:0] files_done_next;

  // a data byte always goes; an end of file waits for a free result slot
  assign is_eof    = (stg_item.kind == KIND_EOF);
  assign data_take = stg_valid && !is_eof;
  assign res_push  = stg_valid && is_eof && res_space;
  assign stg_take  = data_take || res_push;

  // file close and totals
  assign final_crc            = running_crc ^ CRC_XOROUT;
  assign crc_accumulator_next = crc_accumulator ^ final_crc;
  assign length_sum_next      = length_sum + byte_count;
  assign files_done_next      = files_done + 32'd1;

  assign res.file_crc     = final_crc;
  assign res.file_length  = byte_count;
  assign res.total_crc    = crc_accumulator_next;
  assign res.total_length = length_sum_next;
  assign res.file_count   = files_done_next;

  // per-file and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc     <= CRC_INIT;
      byte_count      <= '0;
      crc_accumulator <= '0;
      length_sum      <= '0;
      files_done      <= '0;
    end else if (data_take) begin
      running_crc <= crc_byte(running_crc, stg_item.data_byte);
      byte_count  <= byte_count + 32'd1;
    end else if (res_push) begin
      running_crc     <= CRC_INIT;
      byte_count      <= '0;
      crc_accumulator <= crc_accumulator_next;
      length_sum      <= length_sum_next;
      files_done      <= files_done_next;
    end
  end

  // file state restarts after every end of file
  a_restart: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (running_crc == CRC_INIT) && (byte_count == 32'd0))
    else $error("file state not restarted after end of file");

  // each data byte adds exactly one to the length
  a_count: assert property (@(posedge clk) disable iff (rst)
    data_take |=> byte_count == $past(byte_count) + 32'd1)
    else $error("byte count did not advance on data byte");

  // each result counts one more file
  a_files: assert property (@(posedge clk) disable iff (rst)
    res_push |=> files_done == $past(files_done) + 32'd1)
    else $error("file count did not advance on result");

  // nothing pushed into a full result slot
  a_space: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_space)
    else $error("result pushed without space");

endmodule

`default_nettype wire

// ===== rtl/core/crcft_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crcft_out_stage
  import crcft_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    res_push,
  input  wire result_t res,
  output logic         res_space,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_res
);

  // slot free when empty or being read this cycle
  assign res_space = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_space) begin
      out_valid <= res_push;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_push && res_space) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

// ===== verif/crc32_file_checksum_with_totals_top_tb.sv =====
`timescale 1ns / 1ps

module crc32_file_checksum_with_totals_top_tb;
  import crcft_pkg::*;

  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned TAIL_CYCLES  = 10;

  // expected file results, built from accepted input transfers
  class crc_file_scoreboard;
    logic [31:0] crc_reg;
    logic [31:0] byte_cnt;
    logic [31:0] crc_xor_total;
    logic [31:0] length_total;
    logic [31:0] files_closed;
    result_t     file_results_q[$];
    int unsigned mismatches;

    function new();
      crc_reg       = CRC_INIT;
      byte_cnt      = '0;
      crc_xor_total = '0;
      length_total  = '0;
      files_closed  = '0;
      mismatches    = 0;
    endfunction

    // reflected crc, one input bit at a time, lsb first
    function logic [31:0] crc_advance(logic [31:0] c, logic [7:0] b);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c  = c >> 1;
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void note_input(kind_t k, logic [7:0] b);
      result_t r;
      if (k == KIND_DATA) begin
        crc_reg  = crc_advance(crc_reg, b);
        byte_cnt = byte_cnt + 32'd1;
      end else begin
        r.file_crc     = crc_reg ^ CRC_XOROUT;
        r.file_length  = byte_cnt;
        crc_xor_total  = crc_xor_total ^ r.file_crc;
        length_total   = length_total + byte_cnt;
        files_closed   = files_closed + 32'd1;
        r.total_crc    = crc_xor_total;
        r.total_length = length_total;
        r.file_count   = files_closed;
        file_results_q.push_back(r);
        crc_reg  = CRC_INIT;
        byte_cnt = '0;
      end
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (file_results_q.size() == 0) begin
        report($sformatf("output transfer with no file pending, crc %h", got.file_crc));
      end else begin
        want = file_results_q.pop_front();
        if (got.file_crc !== want.file_crc)
          report($sformatf("file_crc got %h want %h", got.file_crc, want.file_crc));
        if (got.file_length !== want.file_length)
          report($sformatf("file_length got %h want %h", got.file_length, want.file_length));
        if (got.total_crc !== want.total_crc)
          report($sformatf("total_crc got %h want %h", got.total_crc, want.total_crc));
        if (got.total_length !== want.total_length)
          report($sformatf("total_length got %h want %h", got.total_length,
                           want.total_length));
        if (got.file_count !== want.file_count)
          report($sformatf("file_count got %h want %h", got.file_count, want.file_count));
      end
    endtask

    function int pending();
      return file_results_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] file_crc;
  logic [31:0] file_length;
  logic [31:0] total_crc;
  logic [31:0] total_length;
  logic [31:0] file_count;

  crc_file_scoreboard sb;
  bit          no_idle;
  int unsigned stall_cycles;
  int unsigned items_sent;
  logic [7:0]  check_str [9] = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};

  crc32_file_checksum_with_totals_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .file_crc     (file_crc),
    .file_length  (file_length),
    .total_crc    (total_crc),
    .total_length (total_length),
    .file_count   (file_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 38);
    end
  end

  // transfer monitor and stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(kind_t'(kind), data_byte);
      if (out_valid && out_ready)
        sb.check_result({file_crc, file_length, total_crc, total_length, file_count});
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // one input transfer, each cycle in front idle at random
  task send_item(kind_t k, logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    data_byte <= b;
    items_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender off until every closed file has come out
  task drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned len;
    int unsigned file_idx;
    int unsigned pick;

    sb           = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = 1'b0;
    data_byte    = 8'h00;
    no_idle      = 1'b0;
    stall_cycles = 0;
    items_sent   = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty files, byte extremes, ignored byte on file close
    send_item(KIND_EOF, 8'hFF);
    send_item(KIND_EOF, 8'h00);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_EOF, 8'hA5);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_EOF, 8'h5A);
    foreach (check_str[i]) send_item(KIND_DATA, check_str[i]);
    send_item(KIND_EOF, 8'h00);
    send_item(KIND_DATA, 8'h80);
    send_item(KIND_DATA, 8'h01);
    send_item(KIND_EOF, 8'hFF);
    drain_results();

    // random files, mostly short, a few long
    items_sent = 0;
    file_idx   = 0;
    while (items_sent < RANDOM_ITEMS) begin
      no_idle = (file_idx >= 10 && file_idx < 20);
      if (file_idx == 30) drain_results();
      pick = $urandom_range(99);
      if (pick < 15)      len = 0;
      else if (pick < 80) len = $urandom_range(1, 8);
      else if (pick < 95) len = $urandom_range(9, 24);
      else                len = $urandom_range(25, 60);
      repeat (len) send_item(KIND_DATA, 8'($urandom()));
      send_item(KIND_EOF, 8'($urandom()));
      file_idx++;
    end
    no_idle = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
